// File: rtl/bch_pkg.sv
package bch_pkg;

   // codeword geometry
   localparam int unsigned CW_BITS   = 63;
   localparam int unsigned DATA_BITS = 56;
   localparam int unsigned PAR_BITS  = CW_BITS - DATA_BITS;
   localparam int unsigned REM_BITS  = 6;
   localparam int unsigned POS_BITS  = 7;

   // low terms of g1(x) = x^6 + x + 1
   localparam logic [REM_BITS-1:0] G_LOW = 6'h03;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_CORRECTED = 2'd1;
   localparam logic [1:0] ST_DET_ODD   = 2'd2;
   localparam logic [1:0] ST_DET_EVEN  = 2'd3;

   // position reported when nothing was corrected
   localparam logic [POS_BITS-1:0] POS_NONE = 7'h7F;

   // syndrome stage result
   typedef struct packed {
      logic                valid;
      logic [REM_BITS-1:0] rem;
      logic                par;
   } syn_type;

   // build x^i mod g1(x) for every bit i of the codeword
   function automatic logic [CW_BITS*REM_BITS-1:0] build_syn_tbl();
      logic [CW_BITS*REM_BITS-1:0] tbl;
      logic [REM_BITS-1:0]         r;
      tbl = '0;
      r   = 6'h01;
      for (int i = 0; i < CW_BITS; i++) begin
         tbl[i*REM_BITS +: REM_BITS] = r;
         r = r[REM_BITS-1] ? ({r[REM_BITS-2:0], 1'b0} ^ G_LOW) : {r[REM_BITS-2:0], 1'b0};
      end
      return tbl;
   endfunction

   localparam logic [CW_BITS*REM_BITS-1:0] SYN_TBL = build_syn_tbl();

endpackage

// File: rtl/bch_syn.sv
module bch_syn (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [bch_pkg::CW_BITS-1:0]      in_word,
   output bch_pkg::syn_type                 syn_ff,
   output logic [bch_pkg::DATA_BITS-1:0]    data_ff
);
   import bch_pkg::*;

   logic [CW_BITS-1:0]  word_inv;
   logic [REM_BITS-1:0] rem_in;
   logic                par_in;

   // restore the complemented parity bits
   assign word_inv = in_word ^ {{DATA_BITS{1'b0}}, {PAR_BITS{1'b1}}};

   // remainder as XOR of x^i mod g1 over set bits, plus overall parity
   always_comb begin
      rem_in = '0;
      for (int i = 0; i < CW_BITS; i++) begin
         if (word_inv[i]) begin
            rem_in = rem_in ^ SYN_TBL[i*REM_BITS +: REM_BITS];
         end
      end
      par_in = ^word_inv;
   end

   // hold valid under reset, advance payload
   always_ff @(posedge clock) begin
      if (reset) begin
         syn_ff.valid <= 1'b0;
      end else begin
         syn_ff.valid <= in_valid;
      end
      syn_ff.rem <= rem_in;
      syn_ff.par <= par_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= in_word[CW_BITS-1:PAR_BITS];
   end

endmodule

// File: rtl/bch_loc.sv
module bch_loc (
   input  logic                                clock,
   input  logic                                reset,
   input  bch_pkg::syn_type                    syn,
   input  logic [bch_pkg::DATA_BITS-1:0]       data,
   output logic                                out_valid_ff,
   output logic [bch_pkg::DATA_BITS-1:0]       out_data_ff,
   output logic [1:0]                          out_status_ff,
   output logic [bch_pkg::POS_BITS-1:0]        out_pos_ff
);
   import bch_pkg::*;

   logic                  m_valid_ff;
   logic [CW_BITS-1:0]    m_hit_ff;
   logic [CW_BITS-1:0]    hit_in;
   logic [1:0]            m_status_ff;
   logic [1:0]            status_in;
   logic [DATA_BITS-1:0]  m_data_ff;
   logic [DATA_BITS-1:0]  data_in;
   logic [POS_BITS-1:0]   pos_in;
   logic                  want_fix;

   // match the remainder against the column of every position
   assign want_fix = (syn.rem != '0) && syn.par;

   always_comb begin
      for (int k = 0; k < CW_BITS; k++) begin
         hit_in[k] = want_fix &&
                     (syn.rem == SYN_TBL[(CW_BITS-1-k)*REM_BITS +: REM_BITS]);
      end
   end

   // classify the word
   always_comb begin
      if (syn.rem == '0) begin
         status_in = syn.par ? ST_DET_ODD : ST_OK;
      end else if (!syn.par) begin
         status_in = ST_DET_EVEN;
      end else if (hit_in != '0) begin
         status_in = ST_CORRECTED;
      end else begin
         status_in = ST_DET_ODD;
      end
   end

   // match stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= syn.valid;
      end
   end

   always_ff @(posedge clock) begin
      m_hit_ff    <= hit_in;
      m_status_ff <= status_in;
      m_data_ff   <= data;
   end

   // encode the one-hot hit and flip the matching data bit
   always_comb begin
      pos_in = '0;
      for (int k = 0; k < CW_BITS; k++) begin
         if (m_hit_ff[k]) begin
            pos_in = pos_in | POS_BITS'(k);
         end
      end
      if (m_hit_ff == '0) begin
         pos_in = POS_NONE;
      end
      for (int k = 0; k < DATA_BITS; k++) begin
         data_in[DATA_BITS-1-k] = m_data_ff[DATA_BITS-1-k] ^ m_hit_ff[k];
      end
   end

   // output stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff   <= data_in;
      out_status_ff <= m_status_ff;
      out_pos_ff    <= pos_in;
   end

endmodule

// File: rtl/bch_63_56_block_decoder_unit.sv
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+------------------------------
// request   | start, busy, req_code_word              | word taken when start & !busy
// response  | rsp_strobe, rsp_data_out, rsp_status,   | one-cycle strobe, no hold-off
//           | rsp_corrected_position                  |
//
// One word is taken every cycle; busy is always low.
// Each result passes through the four register stages after its word is taken:
// input, syndrome, position match, correct and encode.
// Synchronous active-high reset clears the stage valid bits; payload is not reset.
// The response side has no stall, so the pipeline never holds.
module bch_63_56_block_decoder_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bch_pkg::CW_BITS-1:0]         req_code_word,
   output logic                                rsp_strobe,
   output logic [bch_pkg::DATA_BITS-1:0]       rsp_data_out,
   output logic [1:0]                          rsp_status,
   output logic signed [bch_pkg::POS_BITS-1:0] rsp_corrected_position
);
   import bch_pkg::*;

   logic                 in_valid_ff;
   logic [CW_BITS-1:0]   in_word_ff;
   syn_type              syn;
   logic [DATA_BITS-1:0] syn_data;
   logic [POS_BITS-1:0]  pos;

   assign busy = 1'b0;

   // capture the incoming word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= req_code_word;
   end

   bch_syn u_syn (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_word  (in_word_ff),
      .syn_ff   (syn),
      .data_ff  (syn_data)
   );

   bch_loc u_loc (
      .clock         (clock),
      .reset         (reset),
      .syn           (syn),
      .data          (syn_data),
      .out_valid_ff  (rsp_strobe),
      .out_data_ff   (rsp_data_out),
      .out_status_ff (rsp_status),
      .out_pos_ff    (pos)
   );

   assign rsp_corrected_position = $signed(pos);

`ifndef ASSERT_OFF
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("response strobe missing four cycles after accept");

   a_pos_status : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_status == ST_CORRECTED) == (pos != POS_NONE)))
      else $error("corrected position disagrees with status");

   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_CORRECTED)) |-> (pos < POS_BITS'(CW_BITS)))
      else $error("corrected position out of range");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

   import bch_pkg::*;

   // one decoded word as the response port carries it
   typedef struct packed {
      logic [DATA_BITS-1:0]       data;
      logic [1:0]                 status;
      logic signed [POS_BITS-1:0] pos;
   } decode_type;

   localparam logic [REM_BITS-1:0] REM_TOP   = 6'h20;  // x^5 term of the remainder
   localparam logic [REM_BITS-1:0] INV_X0    = 6'h21;  // x^-1 mod g1, first probe
   localparam logic [PAR_BITS-1:0] PAR_FLIP  = 7'h7F;  // parity is sent complemented
   localparam int                  MAX_SHOWN = 10;
   localparam int                  CYCLE_LIMIT = 200000;

   class decode_scoreboard;
      decode_type  pending[$];
      int unsigned errors;
      int unsigned shown;

      // remainder mod g1 in bits 5..0 and overall parity in bit 6
      function automatic logic [REM_BITS:0] syndrome(input logic [CW_BITS-1:0] v);
         logic [REM_BITS-1:0] rem;
         logic                par;
         logic                top;
         rem = '0;
         par = 1'b0;
         for (int k = CW_BITS - 1; k >= 0; k--) begin
            top = rem[REM_BITS-1];
            par ^= v[k];
            rem = {rem[REM_BITS-2:0], v[k]};
            if (top) rem ^= G_LOW;
         end
         return {par, rem};
      endfunction

      // decode one received word: syndrome, then search the error position
      function automatic decode_type decode_word(input logic [CW_BITS-1:0] cw);
         decode_type          r;
         logic [REM_BITS:0]   syn;
         logic [REM_BITS-1:0] rem;
         logic [REM_BITS-1:0] probe;
         logic                found;
         r.data   = cw[CW_BITS-1:PAR_BITS];
         r.status = ST_OK;
         r.pos    = POS_NONE;
         syn = syndrome(cw ^ {{DATA_BITS{1'b0}}, PAR_FLIP});
         rem = syn[REM_BITS-1:0];
         if (rem == '0) begin
            r.status = syn[REM_BITS] ? ST_DET_ODD : ST_OK;
         end else if (!syn[REM_BITS]) begin
            r.status = ST_DET_EVEN;
         end else begin
            // walk x^-k until it equals the remainder; no match keeps detected odd
            r.status = ST_DET_ODD;
            probe = INV_X0;
            found = 1'b0;
            for (int k = 0; k < CW_BITS; k++) begin
               if (!found && rem == probe) begin
                  found = 1'b1;
                  if (k < DATA_BITS) r.data[DATA_BITS-1-k] = ~r.data[DATA_BITS-1-k];
                  r.pos    = k[POS_BITS-1:0];
                  r.status = ST_CORRECTED;
               end
               probe = probe[0] ? (((probe ^ G_LOW) >> 1) | REM_TOP) : (probe >> 1);
            end
         end
         return r;
      endfunction

      function void note_word(input logic [CW_BITS-1:0] cw);
         pending.push_back(decode_word(cw));
      endfunction

      function void check_result(input logic [DATA_BITS-1:0] data, input logic [1:0] status,
                                 input logic signed [POS_BITS-1:0] pos);
         decode_type want;
         if (pending.size() == 0) begin
            errors++;
            if (shown < MAX_SHOWN) begin
               shown++;
               $display("unexpected result: data %h status %0d pos %0d", data, status, pos);
            end
            return;
         end
         want = pending.pop_front();
         if (data !== want.data || status !== want.status || pos !== want.pos) begin
            errors++;
            if (shown < MAX_SHOWN) begin
               shown++;
               $display("mismatch: data %h/%h status %0d/%0d pos %0d/%0d (expected/actual)",
                        want.data, data, want.status, status, want.pos, pos);
            end
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [CW_BITS-1:0]         req_code_word = '0;
   logic                       rsp_strobe;
   logic [DATA_BITS-1:0]       rsp_data_out;
   logic [1:0]                 rsp_status;
   logic signed [POS_BITS-1:0] rsp_corrected_position;

   decode_scoreboard sb = new();
   int               idle_pct = 19;
   int unsigned      cycle_count = 0;
   logic [PAR_BITS-1:0] parity_for_syn [0:(1<<PAR_BITS)-1];

   bch_63_56_block_decoder_unit dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_code_word          (req_code_word),
      .rsp_strobe             (rsp_strobe),
      .rsp_data_out           (rsp_data_out),
      .rsp_status             (rsp_status),
      .rsp_corrected_position (rsp_corrected_position)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // note accepted words first, then check the result on the port
   always @(posedge clock) begin
      if (start === 1'b1 && busy === 1'b0 && !reset) sb.note_word(req_code_word);
      if (rsp_strobe === 1'b1 && !reset)
         sb.check_result(rsp_data_out, rsp_status, rsp_corrected_position);
   end

   // build a valid codeword from the parity table
   function automatic logic [CW_BITS-1:0] make_codeword(input logic [DATA_BITS-1:0] d);
      logic [REM_BITS:0] target;
      target = sb.syndrome({d, {PAR_BITS{1'b0}}});
      return {d, parity_for_syn[target] ^ PAR_FLIP};
   endfunction

   // flip one bit, counted from the first transmitted bit
   function automatic logic [CW_BITS-1:0] flip_at(input logic [CW_BITS-1:0] w, input int p);
      return w ^ ({{(CW_BITS-1){1'b0}}, 1'b1} << (CW_BITS - 1 - p));
   endfunction

   // offer one word, idling at random, and hold it until taken
   task automatic send_word(input logic [CW_BITS-1:0] w);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_code_word <= CW_BITS'({$urandom, $urandom});
         @(posedge clock);
      end
      start <= 1'b1;
      req_code_word <= w;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   initial begin
      logic [CW_BITS-1:0]   directed[$];
      logic [CW_BITS-1:0]   w;
      logic [DATA_BITS-1:0] d;
      logic [DATA_BITS-1:0] ones;
      int                   kind;
      int                   p1;
      int                   p2;

      // map each parity syndrome back to its parity field
      for (int q = 0; q < (1 << PAR_BITS); q++)
         parity_for_syn[sb.syndrome({{DATA_BITS{1'b0}}, q[PAR_BITS-1:0]})] = q[PAR_BITS-1:0];

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed words: extremes, clean words, single errors at the edges of
      // data and parity, double and triple errors, zero remainder with odd parity
      ones = '1;
      directed.push_back('0);
      directed.push_back('1);
      directed.push_back(CW_BITS'({(CW_BITS+1)/2{2'b01}}));
      directed.push_back(CW_BITS'({(CW_BITS+1)/2{2'b10}}));
      directed.push_back(make_codeword('0));
      directed.push_back(make_codeword(ones));
      directed.push_back(make_codeword({DATA_BITS/8{8'hA5}}));
      directed.push_back(flip_at(make_codeword('0), 0));
      directed.push_back(flip_at(make_codeword('0), 1));
      directed.push_back(flip_at(make_codeword('0), 55));
      directed.push_back(flip_at(make_codeword('0), 56));
      directed.push_back(flip_at(make_codeword('0), 62));
      directed.push_back(flip_at(make_codeword(ones), 30));
      directed.push_back(flip_at(make_codeword(ones), 55));
      directed.push_back(flip_at(make_codeword(ones), 57));
      directed.push_back(flip_at(flip_at(make_codeword('0), 0), 62));
      directed.push_back(flip_at(flip_at(make_codeword(ones), 10), 60));
      directed.push_back(flip_at(flip_at(flip_at(make_codeword('0), 1), 2), 3));
      // g1(x) itself: remainder zero, parity odd
      directed.push_back(make_codeword('0) ^ 63'h43);
      directed.push_back(make_codeword(ones) ^ 63'h43);
      foreach (directed[i]) send_word(directed[i]);

      // random words, mostly codewords with zero to three errors
      for (int i = 0; i < 1550; i++) begin
         idle_pct = (i >= 500 && i < 800) ? 0 : 19;
         kind = $urandom_range(99);
         d = DATA_BITS'({$urandom, $urandom});
         w = make_codeword(d);
         p1 = $urandom_range(CW_BITS - 1);
         p2 = (p1 + 1 + $urandom_range(CW_BITS - 2)) % CW_BITS;
         if (kind < 10) begin
            w = CW_BITS'({$urandom, $urandom});
         end else if (kind < 40) begin
            w = w;
         end else if (kind < 75) begin
            w = flip_at(w, p1);
         end else if (kind < 90) begin
            w = flip_at(flip_at(w, p1), p2);
         end else begin
            w = flip_at(flip_at(flip_at(w, p1), p2), $urandom_range(CW_BITS - 1));
         end
         send_word(w);
      end
      start <= 1'b0;

      // drain, then allow the pipeline latency for stray results
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

// File: files.f
rtl/bch_pkg.sv
rtl/bch_syn.sv
rtl/bch_loc.sv
rtl/bch_63_56_block_decoder_unit.sv
verif/testbench.sv
